### rtl/mbps_pkg.sv
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// request and status codes, config register indexes, inter-module structs
// no dependencies
package mbps_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned IDX_W      = 7;
	localparam int unsigned LEN_W      = 8;
	localparam int unsigned COUNT_W    = 48;
	localparam int unsigned OUT_ADDR_W = 48;
	localparam int unsigned CFG_DATA_W = 48;

	// match counter saturates here
	localparam logic [1:0] MATCH_SAT = 2'd2;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_BYTE = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_UNIQUE   = 2'd0,
		ST_NONE     = 2'd1,
		ST_AMBIG    = 2'd2,
		ST_UNUSABLE = 2'd3
	} scan_status_t;

	typedef enum logic {
		CFG_PATTERN_LENGTH = 1'b0,
		CFG_REGION_BASE    = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  index;
		logic [BYTE_W-1:0] value;
		logic              care;
	} pat_load_t;

	typedef struct packed {
		logic              en;
		logic [BYTE_W-1:0] value;
	} win_shift_t;

endpackage

### rtl/mbps_pattern_store.sv
// mbps_pattern_store: pattern entry registers and the view of the pattern
// aligned to the byte window (entry n-1-a against window age a)
// depends on mbps_pkg
module mbps_pattern_store
	import mbps_pkg::*;
#(
	parameter int unsigned PATTERN_MAX = 128,
	localparam int unsigned N_W = $clog2(PATTERN_MAX + 1)
) (
	input  logic                                 clk,
	input  pat_load_t                            load,
	input  logic [LEN_W-1:0]                     pattern_length,
	output logic [PATTERN_MAX-1:0][BYTE_W-1:0]   al_byte,
	output logic [PATTERN_MAX-1:0]               al_care,
	output logic [N_W-1:0]                       used_len,
	output logic                                 usable
);

	logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_byte_q;
	logic [PATTERN_MAX-1:0]             pat_care_q;
	logic [LEN_W:0]                     len_ext;
	logic [N_W-1:0]                     shamt;
	logic [PATTERN_MAX-1:0][BYTE_W:0]   stg [N_W+1];

	// loads beyond the store are dropped since no lane matches
	always_ff @(posedge clk) begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (load.en && ({1'b0, load.index} == 8'(i))) begin
				pat_byte_q[i] <= load.value;
				pat_care_q[i] <= load.care;
			end
		end
	end

	assign len_ext  = {1'b0, pattern_length};
	assign used_len = (len_ext > (LEN_W+1)'(PATTERN_MAX)) ? N_W'(PATTERN_MAX)
	                                                    : N_W'(len_ext);
	assign shamt    = N_W'(PATTERN_MAX) - used_len;

	// reverse the pattern, then log shifter down by PATTERN_MAX - n with zero fill
	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			stg[0][k] = {pat_care_q[PATTERN_MAX-1-k], pat_byte_q[PATTERN_MAX-1-k]};
		end
		for (int b = 0; b < N_W; b++) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				if (!shamt[b]) begin
					stg[b+1][k] = stg[b][k];
				end else if (k + (1 << b) < PATTERN_MAX) begin
					stg[b+1][k] = stg[b][k + (1 << b)];
				end else begin
					stg[b+1][k] = '0;
				end
			end
		end
		for (int k = 0; k < PATTERN_MAX; k++) begin
			al_care[k] = stg[N_W][k][BYTE_W];
			al_byte[k] = stg[N_W][k][BYTE_W-1:0];
		end
	end

	// lanes beyond n carry no care bit, so this covers only the used entries
	assign usable = |al_care;

endmodule

### rtl/mbps_window_cmp.sv
// mbps_window_cmp: shift register window of region bytes, newest at lane 0,
// and the masked compare of the shifted window against the aligned pattern
// depends on mbps_pkg
module mbps_window_cmp
	import mbps_pkg::*;
#(
	parameter int unsigned PATTERN_MAX = 128
) (
	input  logic                               clk,
	input  win_shift_t                         shift,
	input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] al_byte,
	input  logic [PATTERN_MAX-1:0]             al_care,
	output logic                               all_match
);

	logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_q;
	logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_nxt;
	logic [PATTERN_MAX-1:0]             lane_ok;

	always_comb begin
		win_nxt[0] = shift.value;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_nxt[k] = win_q[k-1];
		end
	end

	// compare against the window as it stands with the new byte in
	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			lane_ok[k] = !al_care[k] || (win_nxt[k] == al_byte[k]);
		end
	end

	assign all_match = &lane_ok;

	// stale lanes are harmless: the byte count gates every hit
	always_ff @(posedge clk) begin
		if (shift.en) begin
			win_q <= win_nxt;
		end
	end

endmodule

### rtl/masked_byte_pattern_scanner.sv
// masked_byte_pattern_scanner: top level, input stage, scan counters,
// config registers and the result register
// depends on mbps_pkg, mbps_pattern_store, mbps_window_cmp
//
// Usage: write pattern_length and region_base on the cfg channel, load
// pattern entries as items with req_type 0, then stream region bytes as
// items with req_type 1, end_of_region set on the last one. Only that last
// byte gives a result item: scan_status and match_address.
// Loads and bytes may be mixed; a load is seen by the next byte.
// An item is registered in the input stage at acceptance and worked from
// there; a result is registered as its end-of-region byte leaves that stage.
// Throughput: one item per cycle, set by the combinational window compare
// of all PATTERN_MAX lanes against the incoming byte, unless an end-of-region byte waits.
// A result waiting in the output register does not stop load and byte
// items; only a second end-of-region byte waits in the input stage until
// the receiver takes the first result.
// Reset clears the length, base, byte count, match count and all valid
// flags; pattern entries hold whatever they held until loaded.
// cfg_ready is always high.
module masked_byte_pattern_scanner
	import mbps_pkg::*;
#(
	parameter int unsigned PATTERN_MAX  = 128,
	parameter int unsigned ADDRESS_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [IDX_W-1:0]      pattern_index,
	input  logic [BYTE_W-1:0]     byte_value,
	input  logic                  care_bit,
	input  logic                  end_of_region,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            scan_status,
	output logic [OUT_ADDR_W-1:0] match_address,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned N_W    = $clog2(PATTERN_MAX + 1);
	localparam int unsigned DIFF_W = COUNT_W + 1;
	localparam logic [OUT_ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= OUT_ADDR_W) ? '1 :
		OUT_ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

	// config registers
	logic [LEN_W-1:0]      length_q;
	logic [OUT_ADDR_W-1:0] base_q;

	// input stage
	logic                  s1_valid;
	req_type_t             s1_req;
	logic [IDX_W-1:0]      s1_index;
	logic [BYTE_W-1:0]     s1_byte;
	logic                  s1_care;
	logic                  s1_eor;

	// scan state
	logic [COUNT_W-1:0]    seen_q;
	logic [1:0]            cnt_q;
	logic [COUNT_W-1:0]    first_q;

	// result register
	logic                  out_valid_q;
	scan_status_t          status_q;
	logic [COUNT_W-1:0]    off_q;

	logic                               can_take;
	logic                               stall;
	logic                               s1_go;
	logic                               byte_go;
	logic                               result_go;
	pat_load_t                          load;
	win_shift_t                         shift;
	logic [PATTERN_MAX-1:0][BYTE_W-1:0] al_byte;
	logic [PATTERN_MAX-1:0]             al_care;
	logic [N_W-1:0]                     used_len;
	logic                               usable;
	logic                               all_match;
	logic [COUNT_W-1:0]                 seen_new;
	logic [DIFF_W-1:0]                  diff;
	logic                               hit;
	logic [1:0]                         cnt_new;
	logic [COUNT_W-1:0]                 first_new;
	scan_status_t                       status_new;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			base_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_LENGTH: length_q <= cfg_data[LEN_W-1:0];
				CFG_REGION_BASE:    base_q   <= cfg_data[OUT_ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// only an end-of-region byte needs room in the result register
	assign can_take  = !out_valid_q || out_ready;
	assign stall     = s1_valid && (s1_req == REQ_BYTE) && s1_eor && !can_take;
	assign in_ready  = !stall;
	assign s1_go     = s1_valid && !stall;
	assign byte_go   = s1_go && (s1_req == REQ_BYTE);
	assign result_go = byte_go && s1_eor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			s1_req   <= req_type_t'(req_type);
			s1_index <= pattern_index;
			s1_byte  <= byte_value;
			s1_care  <= care_bit;
			s1_eor   <= end_of_region;
		end
	end

	assign load.en    = s1_go && (s1_req == REQ_LOAD);
	assign load.index = s1_index;
	assign load.value = s1_byte;
	assign load.care  = s1_care;

	assign shift.en    = byte_go;
	assign shift.value = s1_byte;

	mbps_pattern_store #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_store (
		.clk           (clk),
		.load          (load),
		.pattern_length(length_q),
		.al_byte       (al_byte),
		.al_care       (al_care),
		.used_len      (used_len),
		.usable        (usable)
	);

	mbps_window_cmp #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_window (
		.clk      (clk),
		.shift    (shift),
		.al_byte  (al_byte),
		.al_care  (al_care),
		.all_match(all_match)
	);

	// saturating byte count; the borrow of seen - n says the window is not yet full
	assign seen_new  = (seen_q == '1) ? seen_q : seen_q + 1'b1;
	assign diff      = {1'b0, seen_new} - DIFF_W'(used_len);
	assign hit       = usable && !diff[COUNT_W] && all_match;
	assign cnt_new   = (hit && (cnt_q != MATCH_SAT)) ? cnt_q + 2'd1 : cnt_q;
	assign first_new = (hit && (cnt_q == 2'd0)) ? diff[COUNT_W-1:0] : first_q;

	always_comb begin
		if (!usable) begin
			status_new = ST_UNUSABLE;
		end else if (cnt_new == 2'd0) begin
			status_new = ST_NONE;
		end else if (cnt_new == 2'd1) begin
			status_new = ST_UNIQUE;
		end else begin
			status_new = ST_AMBIG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			cnt_q   <= '0;
			first_q <= '0;
		end else if (result_go) begin
			seen_q  <= '0;
			cnt_q   <= '0;
			first_q <= '0;
		end else if (byte_go) begin
			seen_q  <= seen_new;
			cnt_q   <= cnt_new;
			first_q <= first_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_go) begin
			status_q <= status_new;
			off_q    <= first_new;
		end
	end

	// base is to be held steady by the user while a result waits; the block does not enforce it
	assign out_valid     = out_valid_q;
	assign scan_status   = status_q;
	assign match_address = (status_q == ST_UNIQUE) ? ((base_q + off_q) & ADDR_MASK) : '0;

endmodule

### tb/mbps_scan_checker.sv
// mbps_scan_checker: watches the cfg, item and result channels of the scanner,
// predicts every scan result and compares it field by field
// depends on mbps_pkg
module mbps_scan_checker
	import mbps_pkg::*;
#(
	parameter int unsigned PATTERN_MAX = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  req_type,
	input  logic [IDX_W-1:0]      pattern_index,
	input  logic [BYTE_W-1:0]     byte_value,
	input  logic                  care_bit,
	input  logic                  end_of_region,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            scan_status,
	input  logic [OUT_ADDR_W-1:0] match_address,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           open_scans,
	output int unsigned           fail_count,
	output logic [3:0][31:0]      status_tally
);

	typedef struct packed {
		scan_status_t          status;
		logic [OUT_ADDR_W-1:0] addr;
	} scan_result_t;

	logic [BYTE_W-1:0]     sig_byte [PATTERN_MAX];
	logic                  sig_care [PATTERN_MAX];
	logic [BYTE_W-1:0]     recent   [PATTERN_MAX];
	logic [COUNT_W-1:0]    fed_count;
	logic [1:0]            hits;
	logic [COUNT_W-1:0]    first_hit_ofs;
	logic [LEN_W-1:0]      sig_len;
	logic [OUT_ADDR_W-1:0] base_addr;
	scan_result_t          expected_scans [$];
	int unsigned           errs;
	logic [3:0][31:0]      tally;

	task automatic clear_scan();
		for (int k = 0; k < PATTERN_MAX; k++) recent[k] = '0;
		fed_count     = '0;
		hits          = '0;
		first_hit_ofs = '0;
	endtask

	// one region byte: shift it in, test the window that it completes,
	// and on the region's last byte queue the result
	task automatic shift_and_match(input logic [BYTE_W-1:0] b, input logic last);
		int unsigned  used;
		logic         usable;
		logic         hit;
		scan_result_t res;
		used   = (sig_len > PATTERN_MAX) ? PATTERN_MAX : sig_len;
		usable = 1'b0;
		for (int j = 0; j < used; j++) if (sig_care[j]) usable = 1'b1;
		for (int k = PATTERN_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
		recent[0] = b;
		if (fed_count != '1) fed_count++;
		if (usable && fed_count >= used) begin
			hit = 1'b1;
			// recent[0] is the newest byte, so entry j lines up with recent[used-1-j]
			for (int j = 0; j < used; j++)
				if (sig_care[j] && recent[used-1-j] != sig_byte[j]) hit = 1'b0;
			if (hit) begin
				if (hits == 0) first_hit_ofs = fed_count - used;
				if (hits < MATCH_SAT) hits++;
			end
		end
		if (last) begin
			res.addr = '0;
			if (!usable)
				res.status = ST_UNUSABLE;
			else if (hits == 0)
				res.status = ST_NONE;
			else if (hits == 1) begin
				res.status = ST_UNIQUE;
				res.addr   = base_addr + first_hit_ofs;
			end else
				res.status = ST_AMBIG;
			expected_scans.insert(expected_scans.size(), res);
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				sig_byte[k] = '0;
				sig_care[k] = 1'b0;
			end
			clear_scan();
			sig_len   = '0;
			base_addr = '0;
			expected_scans.delete();
			errs  = 0;
			tally = '0;
			open_scans   <= 0;
			fail_count   <= 0;
			status_tally <= '0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_scans.size() == 0) begin
					$error("result with nothing expected: scan_status %0d match_address %h",
						scan_status, match_address);
					errs++;
				end else begin
					want = expected_scans.pop_front();
					tally[want.status]++;
					if (scan_status !== want.status) begin
						$error("scan_status: expected %0d, got %0d", want.status, scan_status);
						errs++;
					end
					if (match_address !== want.addr) begin
						$error("match_address: expected %h, got %h", want.addr, match_address);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PATTERN_LENGTH: sig_len   = cfg_data[LEN_W-1:0];
					CFG_REGION_BASE:    base_addr = cfg_data[OUT_ADDR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (req_type == REQ_LOAD) begin
					sig_byte[pattern_index] = byte_value;
					sig_care[pattern_index] = care_bit;
				end else
					shift_and_match(byte_value, end_of_region);
			end
			open_scans   <= expected_scans.size();
			fail_count   <= errs;
			status_tally <= tally;
		end
	end

endmodule

### tb/tb_masked_byte_pattern_scanner.sv
// tb_masked_byte_pattern_scanner: drives directed and random pattern loads,
// region bytes and register writes into the scanner and reports the verdict
// depends on mbps_pkg, masked_byte_pattern_scanner, mbps_scan_checker
module tb_masked_byte_pattern_scanner;
	import mbps_pkg::*;

	localparam int unsigned PATTERN_MAX  = 128;
	localparam int unsigned RANDOM_ITEMS = 1850;
	localparam int unsigned LIMIT        = 200000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 6;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  req_type;
	logic [IDX_W-1:0]      pattern_index;
	logic [BYTE_W-1:0]     byte_value;
	logic                  care_bit;
	logic                  end_of_region;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            scan_status;
	logic [OUT_ADDR_W-1:0] match_address;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned           open_scans;
	int unsigned           fail_count;
	logic [3:0][31:0]      status_tally;

	// stimulus-side copy of the pattern, used to plant matches and for mid-region reloads
	logic [BYTE_W-1:0]     pat_val [PATTERN_MAX];
	logic                  pat_cmp [PATTERN_MAX];
	logic [BYTE_W-1:0]     region_buf [256];
	int unsigned           used_len;
	int unsigned           item_count;
	int unsigned           cycle_count;
	int unsigned           phase_no;
	int unsigned           rand_start;
	bit                    pressure_done;
	bit                    narrow;
	logic [BYTE_W-1:0]     narrow_base;
	bit                    tx_quiet = 1'b0;
	bit                    rx_quiet = 1'b0;
	bit                    hold_req = 1'b0;

	masked_byte_pattern_scanner #(
		.PATTERN_MAX  (PATTERN_MAX),
		.ADDRESS_BITS (OUT_ADDR_W)
	) i_dut (.*);

	mbps_scan_checker #(
		.PATTERN_MAX (PATTERN_MAX)
	) i_scan_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still open", LIMIT, open_scans);
		$display("tb_masked_byte_pattern_scanner: FAIL");
		$finish;
	end

	// result side: random stalls, quiet stretches, and one long hold-off on request
	initial begin
		int unsigned hold_left;
		bit          hold_taken;
		out_ready  = 1'b0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left--;
				end
			end else
				out_ready <= rx_quiet || ($urandom_range(99) >= 10);
		end
	end

	function automatic logic [BYTE_W-1:0] pick_byte();
		if (narrow) return narrow_base ^ BYTE_W'($urandom_range(1));
		return BYTE_W'($urandom_range(255));
	endfunction

	task automatic send_item(input req_type_t kind, input logic [IDX_W-1:0] idx,
		input logic [BYTE_W-1:0] val, input logic care, input logic last);
		while (!tx_quiet && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= kind;
		pattern_index <= idx;
		byte_value    <= val;
		care_bit      <= care;
		end_of_region <= last;
		do @(posedge clk); while (!in_ready);
		item_count++;
	endtask

	task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val,
		input logic care, input logic last);
		pat_val[idx] = val;
		pat_cmp[idx] = care;
		send_item(REQ_LOAD, idx, val, care, last);
	endtask

	task automatic write_reg(input cfg_index_t which, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering items until every result is back and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_scans != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_bytes(input logic [BYTE_W-1:0] bytes [$]);
		for (int k = 0; k < bytes.size(); k++)
			send_item(REQ_BYTE, IDX_W'($urandom_range(127)), bytes[k],
				1'($urandom_range(1)), k == bytes.size() - 1);
	endtask

	// random region of len bytes with the pattern planted copies times
	task automatic scan_region(input int unsigned len, input int unsigned copies);
		int unsigned      pos;
		logic [IDX_W-1:0] idx;
		for (int k = 0; k < len; k++) region_buf[k] = pick_byte();
		if (used_len > 0 && len >= used_len)
			for (int c = 0; c < copies; c++) begin
				pos = $urandom_range(len - used_len);
				for (int j = 0; j < used_len; j++)
					if (pat_cmp[j]) region_buf[pos + j] = pat_val[j];
			end
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 4) begin
				// a load in mid-region: mostly rewrites an entry unchanged
				idx = IDX_W'($urandom_range(PATTERN_MAX - 1));
				if ($urandom_range(2) != 0)
					load_entry(idx, pat_val[idx], pat_cmp[idx], 1'($urandom_range(1)));
				else
					load_entry(idx, pick_byte(), 1'($urandom_range(1)),
						1'($urandom_range(1)));
			end
			send_item(REQ_BYTE, IDX_W'($urandom_range(127)), region_buf[k],
				1'($urandom_range(1)), k == len - 1);
		end
	endtask

	task automatic run_phase(input int unsigned nr);
		logic [LEN_W-1:0]      len_val;
		logic [CFG_DATA_W-1:0] base_val;
		int unsigned           care_pct;
		int unsigned           r;
		int unsigned           regions;
		int unsigned           len;
		int unsigned           copies;
		narrow      = ($urandom_range(2) == 0);
		narrow_base = BYTE_W'($urandom_range(255));
		case (nr)
			0: len_val = 8'd128;
			1: len_val = 8'd255;
			2: len_val = 8'd0;
			3: len_val = 8'd1;
			default: begin
				r = $urandom_range(99);
				if (r < 5)       len_val = 8'd0;
				else if (r < 10) len_val = 8'd128;
				else if (r < 14) len_val = LEN_W'($urandom_range(255, 129));
				else if (r < 25) len_val = LEN_W'($urandom_range(127, 9));
				else             len_val = LEN_W'($urandom_range(8, 1));
			end
		endcase
		r = $urandom_range(9);
		if (r == 0 || nr == 2) base_val = '0;
		else if (r == 1)       base_val = '1;
		else if (r == 2)       base_val = '1 - CFG_DATA_W'($urandom_range(200));
		else                   base_val = {16'($urandom), $urandom};
		r = $urandom_range(99);
		if (r < 8)       care_pct = 0;
		else if (r < 30) care_pct = 30;
		else if (r < 70) care_pct = 70;
		else             care_pct = 100;

		write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len_val));
		write_reg(CFG_REGION_BASE, base_val);
		used_len = (len_val > PATTERN_MAX) ? PATTERN_MAX : len_val;
		for (int j = 0; j < used_len; j++)
			load_entry(IDX_W'(j), pick_byte(), $urandom_range(99) < care_pct,
				$urandom_range(4) == 0);

		regions = (used_len > 32) ? $urandom_range(2, 1) : $urandom_range(6, 2);
		repeat (regions) begin
			if ($urandom_range(99) < 15 && used_len > 1)
				len = $urandom_range(used_len - 1, 1);
			else
				len = used_len + $urandom_range((used_len > 32) ? 24 : 16);
			if (len == 0) len = 1;
			r = $urandom_range(99);
			if (r < 40)      copies = 1;
			else if (r < 60) copies = 2;
			else if (r < 70) copies = 3;
			else             copies = 0;
			scan_region(len, copies);
		end
		settle();
	endtask

	// hold the result side off while one- and two-byte regions keep coming, so the
	// scanner backs up and drops in_ready
	task automatic fill_up();
		write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(1));
		write_reg(CFG_REGION_BASE, {16'($urandom), $urandom});
		used_len = 1;
		load_entry(IDX_W'(0), pick_byte(), 1'b1, 1'b0);
		hold_req = 1'b1;
		repeat (30) scan_region($urandom_range(2, 1), $urandom_range(1));
		settle();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = REQ_LOAD;
		pattern_index = '0;
		byte_value    = '0;
		care_bit      = 1'b0;
		end_of_region = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_PATTERN_LENGTH;
		cfg_data      = '0;
		item_count    = 0;
		pressure_done = 1'b0;
		narrow        = 1'b0;
		narrow_base   = '0;
		used_len      = 0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			pat_val[k] = '0;
			pat_cmp[k] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no pattern after reset
		send_bytes('{8'h5A});
		settle();
		write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(3));
		used_len = 3;
		load_entry(IDX_W'(0), 8'h00, 1'b1, 1'b0);
		load_entry(IDX_W'(1), 8'hFF, 1'b0, 1'b1);
		load_entry(IDX_W'(2), 8'hFF, 1'b1, 1'b0);
		send_bytes('{8'h00, 8'hAA, 8'hFF});                      // hit at offset zero
		send_bytes('{8'h11});                                    // region shorter than pattern
		send_bytes('{8'h00, 8'h12, 8'hFF, 8'h00, 8'h34, 8'hFF}); // two hits
		settle();
		write_reg(CFG_REGION_BASE, '1);
		send_bytes('{8'h00, 8'h7F, 8'hFF});                      // top address
		send_bytes('{8'h22, 8'h00, 8'h55, 8'hFF});               // address wraps to zero
		load_entry(IDX_W'(0), 8'h00, 1'b0, 1'b0);
		load_entry(IDX_W'(2), 8'hFF, 1'b0, 1'b0);
		send_bytes('{8'h00});                                    // all entries wildcards
		settle();

		phase_no   = 0;
		rand_start = item_count;
		while (item_count - rand_start < RANDOM_ITEMS) begin
			tx_quiet = (item_count - rand_start >= 500) && (item_count - rand_start < 850);
			rx_quiet = tx_quiet;
			if (!pressure_done && item_count - rand_start >= 1000) begin
				fill_up();
				pressure_done = 1'b1;
			end else begin
				run_phase(phase_no);
				phase_no++;
			end
		end
		settle();

		$display("%0d items over %0d pattern setups plus a back-pressure burst",
			item_count, phase_no);
		$display("results checked: %0d unique, %0d none, %0d ambiguous, %0d unusable",
			status_tally[ST_UNIQUE], status_tally[ST_NONE], status_tally[ST_AMBIG],
			status_tally[ST_UNUSABLE]);
		if (fail_count == 0 && open_scans == 0)
			$display("tb_masked_byte_pattern_scanner: PASS");
		else
			$display("tb_masked_byte_pattern_scanner: FAIL");
		$finish;
	end

endmodule
